// ===== src/iols_pkg.sv =====
// iols_pkg: shared constants, action and status codes and the cell command
// type for the indexed ordered list store. No dependencies.
`default_nettype none

package iols_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 4;
  localparam int POS_W    = 4;
  localparam int ST_W     = 2;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_W     = ((ACT_W + POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W    = ((DATA_W + CNT_W + ST_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_INSERT     = 4'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE     = 4'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd3;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd6;
  localparam logic [ACT_W-1:0] ACT_READ       = 4'd7;
  localparam logic [ACT_W-1:0] ACT_WRITE      = 4'd8;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [DATA_W-1:0] OUT_OF_RANGE_READ = 32'd7;

  // cell command kinds
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_WRITE  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/iols_cell.sv =====
// iols_cell: one list slot; loads, holds or takes a neighbour's element
// as the broadcast command says. Depends on iols_pkg.
`default_nettype none

module iols_cell
  import iols_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [CMP_W-1:0]  idx,
  input  wire cell_cmd_t         cmd,
  input  wire logic [DATA_W-1:0] lower_data,
  input  wire logic [DATA_W-1:0] upper_data,
  output logic      [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.kind)
      CMD_INSERT: begin
        // slots above the gap move up by one
        if (idx > cmd.pos) begin
          data_next = lower_data;
        end else if (idx == cmd.pos) begin
          data_next = cmd.value;
        end
      end
      CMD_REMOVE: begin
        if (idx >= cmd.pos) begin
          data_next = upper_data;
        end
      end
      CMD_WRITE: begin
        if (idx == cmd.pos) begin
          data_next = cmd.value;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== src/iols_chain.sv =====
// iols_chain: the row of list cells, each wired to the neighbours it has; the end cells see zero.
// Depends on iols_pkg and iols_cell.
`default_nettype none

module iols_chain
  import iols_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_cmd_t         cmd,
  output logic      [DATA_W-1:0] slots [CAPACITY]
);

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] lower_data;
      logic [DATA_W-1:0] upper_data;

      if (i == 0) begin : g_bottom
        assign lower_data = '0;
      end else begin : g_lower
        assign lower_data = slots[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
        assign upper_data = '0;
      end else begin : g_upper
        assign upper_data = slots[i+1];
      end

      iols_cell u_cell (
        .clk        (clk),
        .idx        (CMP_W'(i)),
        .cmd        (cmd),
        .lower_data (lower_data),
        .upper_data (upper_data),
        .data       (slots[i])
      );
    end
  endgenerate

endmodule

`default_nettype wire

// ===== src/indexed_ordered_list_store.sv =====
// indexed_ordered_list_store: bounded ordered list of signed words held in
// a row of shifting cells. Depends on iols_pkg and iols_chain.
//
// Usage:
//   A request word comes in on s_tvalid/s_tready/s_tdata: action, position
//   and value. Each request yields exactly one result word on
//   m_tvalid/m_tready/m_tdata: read data, element count after the request
//   and status.
//   The result is registered at the edge that takes the request.
//   Throughput is one request per cycle while s_tready is high; every
//   cell of the row shifts, loads or holds in that same cycle, so insert
//   and remove cost no more than a read.
//   The output register frees in the cycle its word is taken, so s_tready
//   is high whenever the output is empty or m_tready is high. When the
//   receiver stalls the result holds and s_tready drops until it is taken.
//   Reset (rst, synchronous) empties the list and the output register;
//   slot contents are not cleared, as only slots below the count are read.
`default_nettype none

module indexed_ordered_list_store
  import iols_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,  // action[3:0], position[7:4], value[39:8]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata   // read_value[31:0], count[36:32], status[38:37]
);

  logic [ACT_W-1:0]  action;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic              take;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [ST_W-1:0]   status_next;
  logic [DATA_W-1:0] read_next;
  cell_cmd_t         cmd;

  logic [DATA_W-1:0] slots [CAPACITY];
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;
  logic              empty;
  logic              in_range;

  logic [DATA_W-1:0] read_value;
  logic [ST_W-1:0]   status;

  assign action   = s_tdata[ACT_W-1:0];
  assign position = s_tdata[ACT_W+POS_W-1:ACT_W];
  assign value    = s_tdata[ACT_W+POS_W+DATA_W-1:ACT_W+POS_W];

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign in_range = (pos_ext < cnt_ext);

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    read_next   = '0;
    cmd.kind    = CMD_NONE;
    cmd.pos     = pos_ext;
    cmd.value   = value;
    case (action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          cmd.kind   = CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          cmd.kind   = CMD_REMOVE;
          count_next = count - 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.kind   = CMD_INSERT;
          cmd.pos    = cnt_ext;
          count_next = count + 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.kind   = CMD_INSERT;
          cmd.pos    = '0;
          count_next = count + 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_next = ST_RANGE;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_RANGE;
        end else begin
          cmd.kind   = CMD_REMOVE;
          cmd.pos    = '0;
          count_next = count - 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      ACT_READ: begin
        if (in_range) begin
          read_next = slots[pos_ext[IDX_W-1:0]];
        end else begin
          read_next   = OUT_OF_RANGE_READ;
          status_next = ST_RANGE;
        end
      end
      ACT_WRITE: begin
        if (in_range) begin
          cmd.kind = CMD_WRITE;
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    // cells only move on an accepted word
    if (!take) begin
      cmd.kind = CMD_NONE;
    end
  end

  iols_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .slots (slots)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  logic [CNT_W-1:0] count_out;

  always_ff @(posedge clk) begin
    if (take) begin
      read_value <= read_next;
      count_out  <= count_next;
      status     <= status_next;
    end
  end

  assign m_tdata = OUT_W'({status, count_out, read_value});

endmodule

`default_nettype wire
